[hw/rtl/assert_macros.svh]
// assertion helper macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/siur_pkg.sv]
// types, constants and sha-1 helpers of the serial image upload receiver
package siur_pkg;

    // protocol mode
    typedef enum logic [2:0] {
        MD_IDLE, MD_ECHO, MD_SIZE, MD_IMG_DIG, MD_CHK_DIG, MD_DATA
    } t_mode;

    // sequencer state
    typedef enum logic [2:0] {
        SQ_IDLE, SQ_DIV, SQ_ROUND, SQ_ADD, SQ_NEXT
    } t_seq;

    // digest phase
    typedef enum logic [1:0] {DP_PAD1, DP_PAD2, DP_CMP} t_dphase;

    // hash target
    typedef enum logic {TG_CHUNK, TG_IMAGE} t_tgt;

    // divider result use
    typedef enum logic {DV_COUNT, DV_STOP} t_dvuse;

    // dispatch action
    typedef enum logic [2:0] {AC_CCOMP, AC_ICOMP, AC_PAD, AC_CMP, AC_FIN} t_act;

    typedef logic [4:0][31:0]  t_hash;
    typedef logic [15:0][31:0] t_blk;

    localparam t_hash SHA_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                  32'hEFCDAB89, 32'h67452301};

    // reply codes
    localparam logic [2:0] REP_NONE = 3'd0;
    localparam logic [2:0] REP_ACK  = 3'd1;
    localparam logic [2:0] REP_CERR = 3'd2;
    localparam logic [2:0] REP_INFO = 3'd3;
    localparam logic [2:0] REP_UNK  = 3'd4;
    localparam logic [2:0] REP_ECHO = 3'd5;
    localparam logic [2:0] REP_GOOD = 3'd6;
    localparam logic [2:0] REP_BAD  = 3'd7;

    // register indexes
    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_INFO   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_ECHO   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_UPLOAD = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BASE   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_CHUNK  = 3'd4;

    localparam logic [4:0] DIG_LAST  = 5'd19;
    localparam logic [4:0] SIZE_LAST = 5'd3;
    localparam logic [6:0] RND_LAST  = 7'd79;
    localparam logic [6:0] DIV_LAST  = 7'd31;

    // one sha-1 round on a..e held in words 0..4
    function automatic t_hash sha_round(t_hash v, logic [31:0] w, logic [6:0] t);
        logic [31:0] f;
        logic [31:0] k;
        logic [31:0] tmp;
        t_hash r;
        if (t < 7'd20) begin
            f = (v[1] & v[2]) | (~v[1] & v[3]);
            k = 32'h5A827999;
        end else if (t < 7'd40) begin
            f = v[1] ^ v[2] ^ v[3];
            k = 32'h6ED9EBA1;
        end else if (t < 7'd60) begin
            f = (v[1] & v[2]) | (v[1] & v[3]) | (v[2] & v[3]);
            k = 32'h8F1BBCDC;
        end else begin
            f = v[1] ^ v[2] ^ v[3];
            k = 32'hCA62C1D6;
        end
        tmp  = {v[0][26:0], v[0][31:27]} + f + v[4] + k + w;
        r[4] = v[3];
        r[3] = v[2];
        r[2] = {v[1][1:0], v[1][31:2]};
        r[1] = v[0];
        r[0] = tmp;
        return r;
    endfunction

    // message schedule as a shift line
    function automatic t_blk sha_shift(t_blk b);
        logic [31:0] x;
        t_blk r;
        x = b[13] ^ b[8] ^ b[2] ^ b[0];
        for (int i = 0; i < 15; i++) r[i] = b[i+1];
        r[15] = {x[30:0], x[31]};
        return r;
    endfunction

    // store one message byte, big endian in each word
    function automatic t_blk put_byte(t_blk b, logic [5:0] pos, logic [7:0] v);
        t_blk r;
        r = b;
        r[pos[5:2]][(3 - int'(pos[1:0])) * 8 +: 8] = v;
        return r;
    endfunction

    // store one expected digest byte
    function automatic t_hash put_dig(t_hash h, logic [4:0] k, logic [7:0] v);
        t_hash r;
        r = h;
        r[k[4:2]][(3 - int'(k[1:0])) * 8 +: 8] = v;
        return r;
    endfunction

    // padding: first keeps data, marks the end; second is zero; length last
    function automatic t_blk sha_pad(t_blk b, logic [5:0] pos, logic [63:0] bits,
                                     logic first);
        t_blk r;
        int k;
        for (int j = 0; j < 16; j++) begin
            for (int n = 0; n < 4; n++) begin
                k = 4 * j + n;
                if (first && k < int'(pos))
                    r[j][(3 - n) * 8 +: 8] = b[j][(3 - n) * 8 +: 8];
                else if (first && k == int'(pos))
                    r[j][(3 - n) * 8 +: 8] = 8'h80;
                else
                    r[j][(3 - n) * 8 +: 8] = 8'h00;
            end
        end
        if (!first || pos < 6'd56) begin
            r[14] = bits[63:32];
            r[15] = bits[31:0];
        end
        return r;
    endfunction

endpackage

[hw/rtl/serial_image_upload_receiver_top.sv]
// serial image upload receiver: command decode, chunked upload, sha-1 checks
//
//  channel  | valid        | ready        | payload
//  ---------+--------------+--------------+---------------------------------------
//  byte in  | i_valid      | o_ready      | i_rx_byte
//  result   | o_valid      | i_ready      | o_reply o_reply_byte o_mem_write
//           |              |              | o_mem_address o_mem_data
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index i_cfg_data
//
// command, echo and digest bytes are answered from the idle state; the fourth
// size byte and the last digest byte of a final chunk also pass through the
// shift-subtract divider; a data byte may also need sha-1 blocks compressed on the
// one shared round unit: up to 2 for full blocks, 2 for the chunk digest and 2
// for the image digest, so the last byte of an upload takes the longest
// a new byte is taken only once the previous result has left the output register
// reset is synchronous and needs no clearing pass; config is always ready
module serial_image_upload_receiver_top #(
    parameter int ADDRESS_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [2:0]                   o_reply,
    output logic [7:0]                   o_reply_byte,
    output logic                         o_mem_write,
    output logic [31:0]                  o_mem_address,
    output logic [7:0]                   o_mem_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [siur_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [31:0]                  i_cfg_data
);
    import siur_pkg::*;

    localparam int AW = ADDRESS_WIDTH;

    // configuration
    logic [7:0]  r_info_op, r_echo_op, r_upl_op;
    logic [31:0] r_load_base;
    logic [16:0] r_chunk_len;

    // control
    t_seq    r_sq, n_sq;
    t_mode   r_mode;
    t_act    w_act;
    t_dphase r_dphase;
    t_tgt    r_dtgt, r_ctgt;
    t_dvuse  r_dvuse;
    logic    r_ovalid, r_need_cc, r_need_ic, r_done;
    logic [4:0] r_bc;
    logic [6:0] r_cnt;

    // upload state
    logic [31:0]   r_isize, r_chunks_left;
    logic [AW-1:0] r_wp, r_cstart;
    logic [16:0]   r_stop, r_clen;
    logic [31:0]   r_ilen, r_slen;
    t_hash r_ch, r_ih, r_sh, r_exp_c, r_exp_i, r_v;
    t_blk  r_cb, r_ib, r_sb;

    // divider
    logic [31:0] r_dq;
    logic [16:0] r_drem;

    // output register
    logic [2:0]  r_o_reply;
    logic [7:0]  r_o_rbyte, r_o_data;
    logic        r_o_mw;
    logic [31:0] r_o_addr;

    logic        w_in_acc, w_fin, w_match, w_last_size, w_last_cdig, w_ge;
    logic [16:0] w_eff, w_drem_n;
    logic [17:0] w_dt, w_dsub;
    logic [31:0] w_dq_n, w_isize_n;
    logic [31:0] w_wt;
    logic [5:0]  w_pos;
    logic [63:0] w_bits;

    assign w_in_acc    = i_valid && o_ready;
    assign w_eff       = (r_chunk_len == 17'd0) ? 17'd1 : r_chunk_len;
    assign w_last_size = (r_mode == MD_SIZE) && (r_bc == SIZE_LAST);
    assign w_last_cdig = (r_mode == MD_CHK_DIG) && (r_bc == DIG_LAST) &&
                         (r_chunks_left == 32'd0);
    assign w_isize_n   = r_isize | (32'(i_rx_byte) << (int'(r_bc[1:0]) * 8));
    assign w_match     = (r_dtgt == TG_CHUNK) ? (r_ch == r_exp_c) : (r_ih == r_exp_i);
    assign w_fin       = (n_sq == SQ_IDLE) && (r_sq != SQ_IDLE || w_in_acc);

    // divider step
    assign w_dt     = {r_drem, r_dq[31]};
    assign w_dsub   = w_dt - {1'b0, w_eff};
    assign w_ge     = w_dt >= {1'b0, w_eff};
    assign w_drem_n = w_ge ? w_dsub[16:0] : w_dt[16:0];
    assign w_dq_n   = {r_dq[30:0], w_ge};

    // schedule word and padding inputs of the selected hash
    assign w_wt   = (r_ctgt == TG_CHUNK) ? r_cb[0] : r_ib[0];
    assign w_pos  = (r_dtgt == TG_CHUNK) ? r_clen[5:0] : r_ilen[5:0];
    assign w_bits = (r_dtgt == TG_CHUNK) ? {44'd0, r_clen, 3'd0} : {29'd0, r_ilen, 3'd0};

    // dispatch after a byte or a compression
    always_comb begin
        if (r_need_cc)                w_act = AC_CCOMP;
        else if (r_need_ic)           w_act = AC_ICOMP;
        else if (!r_done)             w_act = AC_FIN;
        else if (r_dphase == DP_CMP)  w_act = AC_CMP;
        else                          w_act = AC_PAD;
    end

    // sequencer next state
    always_comb begin
        n_sq = r_sq;
        case (r_sq)
            SQ_IDLE: begin
                if (w_in_acc) begin
                    if (r_mode == MD_DATA)               n_sq = SQ_NEXT;
                    else if (w_last_size || w_last_cdig) n_sq = SQ_DIV;
                end
            end
            SQ_DIV:   if (r_cnt == DIV_LAST) n_sq = SQ_IDLE;
            SQ_ROUND: if (r_cnt == RND_LAST) n_sq = SQ_ADD;
            SQ_ADD:   n_sq = SQ_NEXT;
            SQ_NEXT: begin
                case (w_act)
                    AC_CCOMP, AC_ICOMP, AC_PAD: n_sq = SQ_ROUND;
                    AC_CMP: begin
                        if (r_dtgt == TG_CHUNK && w_match && r_chunks_left == 32'd0)
                            n_sq = SQ_NEXT;
                        else
                            n_sq = SQ_IDLE;
                    end
                    default: n_sq = SQ_IDLE;
                endcase
            end
            default: n_sq = SQ_IDLE;
        endcase
    end

    // port outputs
    always_comb begin
        o_ready       = (r_sq == SQ_IDLE) && !r_ovalid;
        o_cfg_ready   = 1'b1;
        o_valid       = r_ovalid;
        o_reply       = r_o_reply;
        o_reply_byte  = r_o_rbyte;
        o_mem_write   = r_o_mw;
        o_mem_address = r_o_addr;
        o_mem_data    = r_o_data;
    end

    // control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq        <= SQ_IDLE;
            r_ovalid    <= 1'b0;
            r_info_op   <= 8'd0;
            r_echo_op   <= 8'd1;
            r_upl_op    <= 8'd2;
            r_load_base <= 32'h0000_8000;
            r_chunk_len <= 17'd4096;
        end else begin
            r_sq <= n_sq;
            if (w_fin)
                r_ovalid <= 1'b1;
            else if (r_ovalid && i_ready)
                r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INFO:   r_info_op   <= i_cfg_data[7:0];
                    CFG_ECHO:   r_echo_op   <= i_cfg_data[7:0];
                    CFG_UPLOAD: r_upl_op    <= i_cfg_data[7:0];
                    CFG_BASE:   r_load_base <= i_cfg_data;
                    CFG_CHUNK:  r_chunk_len <= i_cfg_data[16:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath: byte handling, shared round unit, divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MD_IDLE;
            r_bc   <= 5'd0;
        end else begin
            case (r_sq)
                SQ_IDLE: begin
                    if (w_in_acc) begin
                        r_o_reply <= REP_NONE;
                        r_o_rbyte <= 8'd0;
                        r_o_mw    <= 1'b0;
                        r_o_addr  <= 32'd0;
                        r_o_data  <= 8'd0;
                        case (r_mode)
                            MD_IDLE: begin
                                if (i_rx_byte == r_info_op) begin
                                    r_o_reply <= REP_INFO;
                                end else if (i_rx_byte == r_echo_op) begin
                                    r_mode <= MD_ECHO;
                                end else if (i_rx_byte == r_upl_op) begin
                                    r_isize       <= 32'd0;
                                    r_bc          <= 5'd0;
                                    r_chunks_left <= 32'd0;
                                    r_wp          <= AW'(r_load_base);
                                    r_cstart      <= AW'(r_load_base);
                                    r_stop        <= 17'd0;
                                    r_ih          <= SHA_INIT;
                                    r_ilen        <= 32'd0;
                                    r_mode        <= MD_SIZE;
                                    r_o_reply     <= REP_ACK;
                                end else begin
                                    r_o_reply <= REP_UNK;
                                    r_o_rbyte <= i_rx_byte;
                                end
                            end
                            MD_ECHO: begin
                                r_o_reply <= REP_ECHO;
                                r_o_rbyte <= i_rx_byte;
                                if (i_rx_byte == 8'd0) r_mode <= MD_IDLE;
                            end
                            MD_SIZE: begin
                                r_isize <= w_isize_n;
                                if (w_last_size) begin
                                    r_bc      <= 5'd0;
                                    r_mode    <= MD_IMG_DIG;
                                    r_o_reply <= REP_ACK;
                                    r_dvuse   <= DV_COUNT;
                                    r_dq      <= w_isize_n;
                                    r_drem    <= 17'd0;
                                    r_cnt     <= 7'd0;
                                end else begin
                                    r_bc <= r_bc + 5'd1;
                                end
                            end
                            MD_IMG_DIG: begin
                                r_exp_i <= put_dig(r_exp_i, r_bc, i_rx_byte);
                                if (r_bc == DIG_LAST) begin
                                    r_bc      <= 5'd0;
                                    r_mode    <= MD_CHK_DIG;
                                    r_o_reply <= REP_ACK;
                                end else begin
                                    r_bc <= r_bc + 5'd1;
                                end
                            end
                            MD_CHK_DIG: begin
                                r_exp_c <= put_dig(r_exp_c, r_bc, i_rx_byte);
                                if (r_bc == DIG_LAST) begin
                                    // chunk start: fresh chunk hash, image snapshot
                                    r_bc      <= 5'd0;
                                    r_o_reply <= REP_ACK;
                                    r_mode    <= MD_DATA;
                                    r_cstart  <= r_wp;
                                    r_ch      <= SHA_INIT;
                                    r_clen    <= 17'd0;
                                    r_sh      <= r_ih;
                                    r_sb      <= r_ib;
                                    r_slen    <= r_ilen;
                                    if (r_chunks_left != 32'd0) begin
                                        r_stop <= w_eff;
                                    end else begin
                                        r_dvuse <= DV_STOP;
                                        r_dq    <= r_isize;
                                        r_drem  <= 17'd0;
                                        r_cnt   <= 7'd0;
                                    end
                                end else begin
                                    r_bc <= r_bc + 5'd1;
                                end
                            end
                            MD_DATA: begin
                                r_o_mw   <= 1'b1;
                                r_o_addr <= 32'(r_wp);
                                r_o_data <= i_rx_byte;
                                r_wp     <= r_wp + AW'(1);
                                r_dtgt   <= TG_CHUNK;
                                r_dphase <= DP_PAD1;
                                if (r_stop == 17'd0) begin
                                    r_done    <= 1'b1;
                                    r_need_cc <= 1'b0;
                                    r_need_ic <= 1'b0;
                                end else begin
                                    r_cb      <= put_byte(r_cb, r_clen[5:0], i_rx_byte);
                                    r_ib      <= put_byte(r_ib, r_ilen[5:0], i_rx_byte);
                                    r_clen    <= r_clen + 17'd1;
                                    r_ilen    <= r_ilen + 32'd1;
                                    r_need_cc <= (r_clen[5:0] == 6'd63);
                                    r_need_ic <= (r_ilen[5:0] == 6'd63);
                                    r_done    <= (r_clen + 17'd1 == r_stop);
                                end
                            end
                            default: r_mode <= MD_IDLE;
                        endcase
                    end
                end
                SQ_DIV: begin
                    r_dq   <= w_dq_n;
                    r_drem <= w_drem_n;
                    r_cnt  <= r_cnt + 7'd1;
                    if (r_cnt == DIV_LAST) begin
                        if (r_dvuse == DV_COUNT) r_chunks_left <= w_dq_n;
                        else                     r_stop        <= w_drem_n;
                    end
                end
                SQ_ROUND: begin
                    r_v   <= sha_round(r_v, w_wt, r_cnt);
                    r_cnt <= r_cnt + 7'd1;
                    if (r_ctgt == TG_CHUNK) r_cb <= sha_shift(r_cb);
                    else                    r_ib <= sha_shift(r_ib);
                end
                SQ_ADD: begin
                    for (int i = 0; i < 5; i++) begin
                        if (r_ctgt == TG_CHUNK) r_ch[i] <= r_ch[i] + r_v[i];
                        else                    r_ih[i] <= r_ih[i] + r_v[i];
                    end
                end
                SQ_NEXT: begin
                    r_cnt <= 7'd0;
                    case (w_act)
                        AC_CCOMP: begin
                            r_need_cc <= 1'b0;
                            r_ctgt    <= TG_CHUNK;
                            r_v       <= r_ch;
                        end
                        AC_ICOMP: begin
                            r_need_ic <= 1'b0;
                            r_ctgt    <= TG_IMAGE;
                            r_v       <= r_ih;
                        end
                        AC_PAD: begin
                            r_ctgt <= r_dtgt;
                            if (r_dtgt == TG_CHUNK) begin
                                r_cb <= sha_pad(r_cb, w_pos, w_bits, r_dphase == DP_PAD1);
                                r_v  <= r_ch;
                            end else begin
                                r_ib <= sha_pad(r_ib, w_pos, w_bits, r_dphase == DP_PAD1);
                                r_v  <= r_ih;
                            end
                            if (r_dphase == DP_PAD1 && w_pos >= 6'd56) r_dphase <= DP_PAD2;
                            else                                       r_dphase <= DP_CMP;
                        end
                        AC_CMP: begin
                            if (r_dtgt == TG_CHUNK) begin
                                if (!w_match) begin
                                    // rewind to chunk start
                                    r_wp      <= r_cstart;
                                    r_ch      <= SHA_INIT;
                                    r_clen    <= 17'd0;
                                    r_ih      <= r_sh;
                                    r_ib      <= r_sb;
                                    r_ilen    <= r_slen;
                                    r_done    <= 1'b0;
                                    r_o_reply <= REP_CERR;
                                end else if (r_chunks_left == 32'd0) begin
                                    r_dtgt   <= TG_IMAGE;
                                    r_dphase <= DP_PAD1;
                                end else begin
                                    r_chunks_left <= r_chunks_left - 32'd1;
                                    r_mode        <= MD_CHK_DIG;
                                    r_done        <= 1'b0;
                                    r_o_reply     <= REP_ACK;
                                end
                            end else begin
                                r_o_reply <= w_match ? REP_GOOD : REP_BAD;
                                r_mode    <= MD_IDLE;
                                r_done    <= 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    `include "assert_macros.svh"

    `ASSERT_SAME(a_round_range, i_clk, i_rst_n, r_sq == SQ_ROUND, r_cnt <= RND_LAST)
    `ASSERT_SAME(a_store_reply, i_clk, i_rst_n, r_ovalid && r_o_mw, r_o_reply != REP_INFO && r_o_reply != REP_UNK && r_o_reply != REP_ECHO)
    `ASSERT_SAME(a_chunk_len, i_clk, i_rst_n, r_sq == SQ_IDLE && r_mode == MD_DATA, r_clen <= r_stop)
    `ASSERT_NEXT(a_cmd_done, i_clk, i_rst_n, w_in_acc && (r_mode == MD_IDLE || r_mode == MD_ECHO), r_ovalid)

endmodule

[sim/siur_tb_sha_pkg.sv]
// sha-1 helpers used by the testbench for digest prediction and stimulus
package siur_tb_sha_pkg;

    typedef logic [4:0][31:0] sha_words_t;
    typedef logic [63:0][7:0] sha_block_t;
    typedef logic [19:0][7:0] sha_digest_t;

    localparam sha_words_t SHA_IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                                     32'hEFCDAB89, 32'h67452301};

    function automatic logic [31:0] rol(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // one 64-byte block folded into the chaining words
    function automatic sha_words_t sha_compress(sha_words_t h, sha_block_t blk);
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        sha_words_t r;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = b ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(b, 30); b = a; a = t;
        end
        r[0] = h[0] + a; r[1] = h[1] + b; r[2] = h[2] + c;
        r[3] = h[3] + d; r[4] = h[4] + e;
        return r;
    endfunction

    // append one message byte
    function automatic void sha_absorb(inout sha_words_t h, inout sha_block_t blk,
                                       inout logic [63:0] n, input logic [7:0] v);
        blk[n[5:0]] = v;
        n = n + 64'd1;
        if (n[5:0] == 6'd0)
            h = sha_compress(h, blk);
    endfunction

    // padded digest of the message so far, state left untouched
    function automatic sha_digest_t sha_final(sha_words_t h, sha_block_t blk,
                                              logic [63:0] n);
        sha_words_t hc;
        sha_block_t bc;
        logic [63:0] lc;
        logic [63:0] bits;
        sha_digest_t out;
        hc = h; bc = blk; lc = n; bits = n << 3;
        sha_absorb(hc, bc, lc, 8'h80);
        while (lc[5:0] != 6'd56)
            sha_absorb(hc, bc, lc, 8'h00);
        for (int i = 0; i < 8; i++)
            sha_absorb(hc, bc, lc, 8'(bits >> (56 - 8 * i)));
        for (int i = 0; i < 20; i++)
            out[i] = 8'(hc[i / 4] >> (24 - 8 * (i % 4)));
        return out;
    endfunction

endpackage

[sim/siur_upload_checker.sv]
// checker: predicts each reply transaction of the receiver and compares it
`timescale 1ns / 1ps
module siur_upload_checker
    import siur_pkg::*;
    import siur_tb_sha_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic [7:0]           i_rx_byte,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [2:0]           i_reply,
    input  logic [7:0]           i_reply_byte,
    input  logic                 i_mem_write,
    input  logic [31:0]          i_mem_address,
    input  logic [7:0]           i_mem_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IW-1:0]    i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output int                   o_pending,
    output int                   o_failures
);

    typedef struct packed {
        logic [2:0]  reply;
        logic [7:0]  rbyte;
        logic        mw;
        logic [31:0] addr;
        logic [7:0]  data;
    } reply_t;

    reply_t replies_due [$];
    int     fail_cnt;

    // register copies
    logic [7:0]  r_info, r_echo, r_upload;
    logic [31:0] r_base;
    logic [16:0] r_chunk;

    // protocol state
    t_mode       mode;
    logic [4:0]  cnt;
    logic [31:0] img_size, chunks_left, wptr, chunk_start, chunk_stop;
    sha_digest_t want_img, want_chunk;
    sha_words_t  ch_h, im_h, snap_h;
    sha_block_t  ch_b, im_b, snap_b;
    logic [63:0] ch_n, im_n, snap_n;

    function automatic logic [31:0] eff_len();
        return (r_chunk == 17'd0) ? 32'd1 : {15'd0, r_chunk};
    endfunction

    task automatic clear_state();
        r_info = 8'd0; r_echo = 8'd1; r_upload = 8'd2;
        r_base = 32'h8000; r_chunk = 17'd4096;
        mode = MD_IDLE; cnt = '0; img_size = '0; chunks_left = '0;
        wptr = '0; chunk_start = '0; chunk_stop = '0;
        want_img = '0; want_chunk = '0;
        ch_h = SHA_IV; ch_b = '0; ch_n = '0;
        im_h = SHA_IV; im_b = '0; im_n = '0;
        snap_h = SHA_IV; snap_b = '0; snap_n = '0;
    endtask

    // next reply for one received byte
    task automatic predict(input logic [7:0] b, output reply_t e);
        logic done;
        sha_digest_t dg;
        e = '0;
        case (mode)
            MD_IDLE: begin
                if (b == r_info) begin
                    e.reply = REP_INFO;
                end else if (b == r_echo) begin
                    mode = MD_ECHO;
                end else if (b == r_upload) begin
                    img_size = '0; cnt = '0; chunks_left = '0;
                    wptr = r_base; chunk_start = r_base; chunk_stop = '0;
                    want_img = '0; want_chunk = '0;
                    im_h = SHA_IV; im_b = '0; im_n = '0;
                    mode = MD_SIZE;
                    e.reply = REP_ACK;
                end else begin
                    e.reply = REP_UNK;
                    e.rbyte = b;
                end
            end
            MD_ECHO: begin
                e.reply = REP_ECHO;
                e.rbyte = b;
                if (b == 8'd0) mode = MD_IDLE;
            end
            MD_SIZE: begin
                img_size = img_size | ({24'd0, b} << (8 * cnt[1:0]));
                cnt = cnt + 5'd1;
                if (cnt >= 5'd4) begin
                    cnt = '0;
                    chunks_left = img_size / eff_len();
                    mode = MD_IMG_DIG;
                    e.reply = REP_ACK;
                end
            end
            MD_IMG_DIG, MD_CHK_DIG: begin
                if (mode == MD_IMG_DIG) want_img[cnt] = b;
                else want_chunk[cnt] = b;
                cnt = cnt + 5'd1;
                if (cnt >= 5'd20) begin
                    cnt = '0;
                    e.reply = REP_ACK;
                    if (mode == MD_IMG_DIG) begin
                        mode = MD_CHK_DIG;
                    end else begin
                        // chunk length is fixed here from the live register
                        chunk_stop = (chunks_left > 0) ? eff_len() : img_size % eff_len();
                        chunk_start = wptr;
                        ch_h = SHA_IV; ch_b = '0; ch_n = '0;
                        snap_h = im_h; snap_b = im_b; snap_n = im_n;
                        mode = MD_DATA;
                    end
                end
            end
            MD_DATA: begin
                e.mw = 1'b1; e.addr = wptr; e.data = b;
                wptr = wptr + 32'd1;
                done = 1'b0;
                if (chunk_stop == 32'd0) begin
                    // empty chunk: the byte is stored but never hashed
                    done = 1'b1;
                end else begin
                    sha_absorb(ch_h, ch_b, ch_n, b);
                    sha_absorb(im_h, im_b, im_n, b);
                    if (ch_n >= {32'd0, chunk_stop}) done = 1'b1;
                end
                if (done) begin
                    dg = sha_final(ch_h, ch_b, ch_n);
                    if (dg != want_chunk) begin
                        // rewind so the chunk data can be sent again
                        wptr = chunk_start;
                        ch_h = SHA_IV; ch_b = '0; ch_n = '0;
                        im_h = snap_h; im_b = snap_b; im_n = snap_n;
                        e.reply = REP_CERR;
                    end else if (chunks_left == 32'd0) begin
                        dg = sha_final(im_h, im_b, im_n);
                        e.reply = (dg == want_img) ? REP_GOOD : REP_BAD;
                        mode = MD_IDLE;
                    end else begin
                        chunks_left = chunks_left - 32'd1;
                        mode = MD_CHK_DIG;
                        e.reply = REP_ACK;
                    end
                end
            end
            default: mode = MD_IDLE;
        endcase
    endtask

    // watch the three channels
    always @(posedge i_clk) begin
        reply_t e;
        reply_t got;
        if (!i_rst_n) begin
            clear_state();
            replies_due.delete();
            fail_cnt = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INFO:   r_info   = i_cfg_data[7:0];
                    CFG_ECHO:   r_echo   = i_cfg_data[7:0];
                    CFG_UPLOAD: r_upload = i_cfg_data[7:0];
                    CFG_BASE:   r_base   = i_cfg_data;
                    CFG_CHUNK:  r_chunk  = i_cfg_data[16:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict(i_rx_byte, e);
                replies_due.push_back(e);
            end
            if (i_out_valid && i_out_ready) begin
                got = '{i_reply, i_reply_byte, i_mem_write, i_mem_address, i_mem_data};
                if (replies_due.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("%0t: reply transaction with none expected: %p", $realtime, got);
                    fail_cnt++;
                end else begin
                    e = replies_due.pop_front();
                    if (got !== e) begin
                        if (fail_cnt < 10)
                            $display("%0t: mismatch exp reply %0d byte %02h mw %0d addr %08h data %02h, got reply %0d byte %02h mw %0d addr %08h data %02h",
                                     $realtime, e.reply, e.rbyte, e.mw, e.addr, e.data,
                                     got.reply, got.rbyte, got.mw, got.addr, got.data);
                        fail_cnt++;
                    end
                end
            end
        end
        o_pending  <= replies_due.size();
        o_failures <= fail_cnt;
    end

endmodule

[sim/tb.sv]
// testbench top: command, echo and upload traffic for the upload receiver
`timescale 1ns / 1ps
module tb;
    import siur_pkg::*;
    import siur_tb_sha_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [7:0] i_rx_byte = 8'd0;
    logic i_ready = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_ready, o_valid, o_mem_write, o_cfg_ready;
    logic [2:0] o_reply;
    logic [7:0] o_reply_byte, o_mem_data;
    logic [31:0] o_mem_address;
    int pending, failures;

    // register values as last written
    logic [7:0]  op_info = 8'd0, op_echo = 8'd1, op_upload = 8'd2;
    logic [16:0] chunk_reg = 17'd4096;

    int bytes_sent = 0;
    int burst_left = 0;
    int stall_style = 0;
    int stall_cnt = 0;

    serial_image_upload_receiver_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_rx_byte(i_rx_byte),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_reply(o_reply), .o_reply_byte(o_reply_byte), .o_mem_write(o_mem_write),
        .o_mem_address(o_mem_address), .o_mem_data(o_mem_data),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    siur_upload_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_ready(o_ready), .i_rx_byte(i_rx_byte),
        .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_reply(o_reply), .i_reply_byte(o_reply_byte), .i_mem_write(o_mem_write),
        .i_mem_address(o_mem_address), .i_mem_data(o_mem_data),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_pending(pending), .o_failures(failures)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stalls, style changes every stretch
    always @(posedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_cnt <= $urandom_range(16, 200);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_style)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // one byte transaction, with bursts and gaps
    task automatic put_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // stop sending and wait for every reply
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] inf, input logic [7:0] ech,
                            input logic [7:0] upl, input logic [31:0] base,
                            input logic [16:0] len);
        cfg_write(CFG_INFO, {8'($urandom_range(0, 255)), 16'd0, inf});
        cfg_write(CFG_ECHO, {24'd0, ech});
        cfg_write(CFG_UPLOAD, {24'd0, upl});
        cfg_write(CFG_BASE, base);
        cfg_write(CFG_CHUNK, {15'd0, len});
        // unmapped index must be ignored
        cfg_write(CFG_CHUNK + CFG_IW'($urandom_range(1, 3)), $urandom());
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        op_info = inf; op_echo = ech; op_upload = upl; chunk_reg = len;
    endtask

    function automatic logic can_echo();
        return op_echo != op_info;
    endfunction

    function automatic logic can_upload();
        return op_upload != op_info && op_upload != op_echo;
    endfunction

    // idle byte that neither opens echo nor starts an upload
    task automatic put_stray();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((can_echo() && b == op_echo) || (can_upload() && b == op_upload));
        put_byte(b);
    endtask

    task automatic do_echo();
        int n;
        logic [7:0] b;
        n = $urandom_range(0, 8);
        put_byte(op_echo);
        repeat (n) begin
            do b = 8'($urandom_range(0, 255)); while (b == 8'd0);
            put_byte(b);
        end
        put_byte(8'd0);
    endtask

    function automatic sha_digest_t digest_of(ref logic [7:0] img [$], input int off,
                                              input int cnt);
        sha_words_t h;
        sha_block_t bk;
        logic [63:0] n;
        h = SHA_IV; bk = '0; n = '0;
        for (int j = 0; j < cnt; j++) sha_absorb(h, bk, n, img[off + j]);
        return sha_final(h, bk, n);
    endfunction

    // well-formed upload, sometimes with a corrupted chunk or a bad image digest
    task automatic do_upload();
        logic [7:0] img [$];
        int len, size, nch, off, clen, cap, flip;
        sha_digest_t dg;
        len = (chunk_reg == 17'd0) ? 1 : int'(chunk_reg);
        cap = (3 * len + 2 < 150) ? 3 * len + 2 : 150;
        size = $urandom_range(0, cap);
        nch = size / len + 1;
        for (int i = 0; i < size; i++) img.push_back(8'($urandom_range(0, 255)));
        dg = digest_of(img, 0, size);
        if ($urandom_range(0, 4) == 0) dg[$urandom_range(0, 19)] ^= 8'h01 << $urandom_range(0, 7);
        put_byte(op_upload);
        for (int i = 0; i < 4; i++) put_byte(8'(size >> (8 * i)));
        for (int i = 0; i < 20; i++) put_byte(dg[i]);
        off = 0;
        for (int c = 0; c < nch; c++) begin
            clen = (c < nch - 1) ? len : size % len;
            dg = digest_of(img, off, clen);
            for (int i = 0; i < 20; i++) put_byte(dg[i]);
            if (clen == 0) begin
                put_byte(8'($urandom_range(0, 255)));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    // corrupted pass, answered with a chunk error and resent
                    flip = $urandom_range(0, clen - 1);
                    for (int j = 0; j < clen; j++)
                        put_byte(j == flip ? img[off + j] ^ (8'h01 << $urandom_range(0, 7))
                                           : img[off + j]);
                end
                for (int j = 0; j < clen; j++) put_byte(img[off + j]);
            end
            off += clen;
        end
    endtask

    // stimulus
    initial begin
        int target, pick;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_regs(8'd0, 8'd1, 8'd2, 32'h0000_8000, 17'd4096);

        // directed: info, unknown extremes, echo with edge bytes
        put_byte(op_info);
        put_byte(8'hFF);
        put_byte(8'h7F);
        put_byte(op_echo);
        put_byte(8'h80);
        put_byte(8'hFF);
        put_byte(8'h01);
        put_byte(8'h00);
        do_upload();

        for (int p = 0; p < 7; p++) begin
            drain();
            case (p)
                0: set_regs(8'd0, 8'd1, 8'd2, 32'h0000_8000, 17'd4096);
                1: set_regs(8'hFF, 8'hFE, 8'hFD, 32'hFFFF_FFF0, 17'd1);
                2: set_regs(8'h10, 8'h20, 8'h30, 32'h0000_0000, 17'd0);
                3: set_regs(8'h44, 8'h44, 8'h55, $urandom(), 17'($urandom_range(2, 40)));
                4: set_regs(8'h66, 8'h77, 8'h77, $urandom(), 17'($urandom_range(2, 40)));
                5: set_regs(8'($urandom_range(0, 84)), 8'($urandom_range(85, 169)),
                            8'($urandom_range(170, 255)), $urandom(), 17'h10000);
                default: set_regs(8'h03, 8'h80, 8'hAA, $urandom(),
                                  17'($urandom_range(2, 70)));
            endcase
            target = 1750 * (p + 1) / 7;
            while (bytes_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 55 && can_upload()) do_upload();
                else if (pick < 75 && can_echo()) do_echo();
                else if (pick < 85) put_byte(op_info);
                else put_stray();
            end
        end

        drain();
        repeat (600) @(posedge i_clk);
        if (failures == 0 && pending == 0)
            $display("serial_image_upload_receiver_top regression: pass");
        else
            $display("serial_image_upload_receiver_top regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("serial_image_upload_receiver_top regression: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/siur_pkg.sv
hw/rtl/serial_image_upload_receiver_top.sv
sim/siur_tb_sha_pkg.sv
sim/siur_upload_checker.sv
sim/tb.sv
